[sv/chtab_pkg.sv]
package chtab_pkg;

    localparam int TABLE_SIZE_DEF = 16;
    localparam int FUNC_W         = 2;
    localparam int KEY_W          = 16;
    localparam int VAL_W          = 16;
    localparam int COUNT_OUT_W    = 5;
    localparam int HASH_BITS      = 8;   // home slot comes from the low key byte

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_e_t;

endpackage

[sv/chtab_if.sv]
interface chtab_in_if import chtab_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  search_key;
    logic [VAL_W-1:0]  new_value;

    modport source (output valid, func, search_key, new_value, input ready);
    modport sink   (input valid, func, search_key, new_value, output ready);
endinterface

interface chtab_out_if import chtab_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [VAL_W-1:0]       found_value;
    logic [COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, ok, found_value, entry_count, input ready);
    modport sink   (input valid, ok, found_value, entry_count, output ready);
endinterface

[sv/chtab_ram.sv]
module chtab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/chtab_home.sv]
// Home slot: the low key byte looked up in a constant table of remainders by
// the table size; the slot is registered and flagged by done in the cycle after start.
module chtab_home import chtab_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [HASH_BITS-1:0]          key_lo,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] home
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int ENTRIES = 1 << HASH_BITS;

    typedef logic [ENTRIES-1:0][IDX_W-1:0] home_table_t;

    function automatic home_table_t build_home_table();
        home_table_t tbl;
        tbl = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl[i] = IDX_W'(i % TABLE_SIZE);
        end
        return tbl;
    endfunction

    localparam home_table_t HOME_TABLE = build_home_table();

    logic             done_reg, done_next;
    logic [IDX_W-1:0] home_reg, home_next;

    assign done = done_reg;
    assign home = home_reg;

    always_comb
    begin
        done_next = start;
        home_next = home_reg;
        if (start)
        begin
            home_next = HOME_TABLE[key_lo];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            home_reg <= '0;
        end
        else
        begin
            done_reg <= done_next;
            home_reg <= home_next;
        end
    end

endmodule

[sv/coalesced_hash_table_top.sv]
// Clear, key zero and the unused code go straight to the result; an insert into an empty
// home slot writes there after the home lookup; otherwise the chain is walked and, for an
// insert that finds no match, free slots are probed (each chain slot is a registered RAM read).
// One item at a time: the next transfer is taken in the cycle after the result is loaded into
// the output register, and loading waits while an earlier result is still unread.
// Reset clears the occupancy and link-valid flops and the entry count at once.
module coalesced_hash_table_top import chtab_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    chtab_in_if.sink    in_ch,
    chtab_out_if.source out_ch
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOME,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [VAL_W-1:0]       val_reg, val_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [IDX_W-1:0]       home_reg, home_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       steps_reg, steps_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TABLE_SIZE-1:0]  occ_reg, occ_next;
    logic [TABLE_SIZE-1:0]  lvalid_reg, lvalid_next;
    logic                   res_ok_reg, res_ok_next;
    logic [VAL_W-1:0]       res_val_reg, res_val_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_ok_reg, out_ok_next;
    logic [VAL_W-1:0]       out_val_reg, out_val_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    logic                   home_start;
    logic                   home_done;
    logic [IDX_W-1:0]       home_idx;

    logic                   kv_we;
    logic                   val_we;
    logic [IDX_W-1:0]       kv_waddr;
    logic                   link_we;
    logic [KEY_W-1:0]       key_rdata;
    logic [VAL_W-1:0]       val_rdata;
    logic [IDX_W-1:0]       link_rdata;
    logic [31:0]            count_ext;
    logic                   in_xfer;
    logic                   last_step;

    chtab_home #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_home (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (home_start),
        .key_lo (in_ch.search_key[HASH_BITS-1:0]),
        .done   (home_done),
        .home   (home_idx)
    );

    chtab_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_key_ram (
        .clk   (clk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata (key_reg),
        .raddr (pos_reg),
        .rdata (key_rdata)
    );

    chtab_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_SIZE)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (kv_waddr),
        .wdata (val_reg),
        .raddr (pos_reg),
        .rdata (val_rdata)
    );

    chtab_ram #(
        .WIDTH (IDX_W),
        .DEPTH (TABLE_SIZE)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (tail_reg),
        .wdata (pos_reg),
        .raddr (pos_reg),
        .rdata (link_rdata)
    );

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign in_xfer            = in_ch.valid && in_ch.ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.ok          = out_ok_reg;
    assign out_ch.found_value = out_val_reg;
    assign out_ch.entry_count = out_count_reg;
    assign count_ext          = 32'(count_reg);
    assign last_step          = (steps_reg == CNT_W'(TABLE_SIZE - 1));

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        home_next      = home_reg;
        tail_next      = tail_reg;
        steps_next     = steps_reg;
        count_next     = count_reg;
        occ_next       = occ_reg;
        lvalid_next    = lvalid_reg;
        res_ok_next    = res_ok_reg;
        res_val_next   = res_val_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_val_next   = out_val_reg;
        out_count_next = out_count_reg;
        home_start     = 1'b0;
        kv_we          = 1'b0;
        val_we         = 1'b0;
        kv_waddr       = pos_reg;
        link_we        = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    func_next    = in_ch.func;
                    key_next     = in_ch.search_key;
                    val_next     = in_ch.new_value;
                    res_ok_next  = 1'b0;
                    res_val_next = '0;
                    unique case (in_ch.func) inside
                        FUNC_CLEAR:
                        begin
                            occ_next    = '0;
                            lvalid_next = '0;
                            count_next  = '0;
                            res_ok_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                        FUNC_INSERT, FUNC_LOOKUP:
                        begin
                            if (in_ch.search_key == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                home_start = 1'b1;
                                state_next = ST_HOME;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_HOME:
            begin
                if (home_done)
                begin
                    pos_next   = home_idx;
                    home_next  = home_idx;
                    steps_next = '0;
                    if ((func_reg == FUNC_INSERT) && !occ_reg[home_idx])
                    begin
                        kv_waddr           = home_idx;
                        kv_we              = 1'b1;
                        val_we             = 1'b1;
                        occ_next[home_idx] = 1'b1;
                        count_next         = count_reg + CNT_W'(1);
                        res_ok_next        = 1'b1;
                        state_next         = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WALK_RD;
                    end
                end
            end

            ST_WALK_RD:
            begin
                // RAM data for pos_reg shows up next cycle
                state_next = ST_WALK_CMP;
            end

            ST_WALK_CMP:
            begin
                if (occ_reg[pos_reg] && (key_rdata == key_reg))
                begin
                    res_ok_next = 1'b1;
                    if (func_reg == FUNC_INSERT)
                    begin
                        val_we = 1'b1;
                    end
                    else
                    begin
                        res_val_next = val_rdata;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    tail_next = pos_reg;
                    if (lvalid_reg[pos_reg] && !last_step)
                    begin
                        pos_next   = link_rdata;
                        steps_next = steps_reg + CNT_W'(1);
                        state_next = ST_WALK_RD;
                    end
                    else if ((func_reg == FUNC_INSERT) &&
                             (count_reg < CNT_W'(TABLE_SIZE)))
                    begin
                        pos_next   = home_reg;
                        steps_next = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!occ_reg[pos_reg])
                begin
                    kv_we                 = 1'b1;
                    val_we                = 1'b1;
                    link_we               = 1'b1;
                    lvalid_next[tail_reg] = 1'b1;
                    occ_next[pos_reg]     = 1'b1;
                    count_next            = count_reg + CNT_W'(1);
                    res_ok_next           = 1'b1;
                    state_next            = ST_DONE;
                end
                else if (last_step)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    pos_next   = (pos_reg == IDX_W'(TABLE_SIZE - 1)) ? '0 : pos_reg + IDX_W'(1);
                    steps_next = steps_reg + CNT_W'(1);
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_val_next   = res_val_reg;
                    out_count_next = count_ext[COUNT_OUT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            func_reg      <= '0;
            key_reg       <= '0;
            val_reg       <= '0;
            pos_reg       <= '0;
            home_reg      <= '0;
            tail_reg      <= '0;
            steps_reg     <= '0;
            count_reg     <= '0;
            occ_reg       <= '0;
            lvalid_reg    <= '0;
            res_ok_reg    <= 1'b0;
            res_val_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_val_reg   <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            key_reg       <= key_next;
            val_reg       <= val_next;
            pos_reg       <= pos_next;
            home_reg      <= home_next;
            tail_reg      <= tail_next;
            steps_reg     <= steps_next;
            count_reg     <= count_next;
            occ_reg       <= occ_next;
            lvalid_reg    <= lvalid_next;
            res_ok_reg    <= res_ok_next;
            res_val_reg   <= res_val_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
            out_val_reg   <= out_val_next;
            out_count_reg <= out_count_next;
        end
    end

endmodule

[tb/tb_coalesced_hash_table_top.sv]
module tb_coalesced_hash_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import chtab_pkg::*;

    localparam int SLOTS         = TABLE_SIZE_DEF;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 3 * SLOTS + 20;
    localparam int PHASE_ITEMS   = 416;

    typedef struct packed {
        func_e_t          func;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic                   ok;
        logic [VAL_W-1:0]       found_value;
        logic [COUNT_OUT_W-1:0] entry_count;
    } reply_t;

    // Shadow copy of the table; each accepted request yields the reply it must produce.
    class table_shadow;
        logic [KEY_W-1:0] keys[SLOTS];
        logic [VAL_W-1:0] vals[SLOTS];
        int unsigned      link[SLOTS];
        bit               link_ok[SLOTS];
        int unsigned      occupied;
        reply_t           replies_due[$];
        int unsigned      error_count;

        function new();
            wipe();
            error_count = 0;
        endfunction

        function void wipe();
            foreach (keys[i])
            begin
                keys[i]    = '0;
                vals[i]    = '0;
                link[i]    = 0;
                link_ok[i] = 1'b0;
            end
            occupied = 0;
        endfunction

        function int unsigned home_of(logic [KEY_W-1:0] key);
            return key[7:0] % SLOTS;
        endfunction

        // Match sets hit; otherwise tail is the last slot visited.
        function bit chain_walk(input logic [KEY_W-1:0] key, output int unsigned hit,
                                output int unsigned tail);
            int unsigned pos;
            pos  = home_of(key);
            hit  = 0;
            tail = 0;
            for (int step = 0; step < SLOTS; step++)
            begin
                if (keys[pos] == key)
                begin
                    hit = pos;
                    return 1'b1;
                end
                tail = pos;
                if (!link_ok[pos])
                    break;
                pos = link[pos] % SLOTS;
            end
            return 1'b0;
        endfunction

        function bit store_pair(logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
            int unsigned home;
            int unsigned hit;
            int unsigned tail;
            int unsigned pos;
            if (key == '0)
                return 1'b0;
            home = home_of(key);
            if (keys[home] == '0)
            begin
                keys[home] = key;
                vals[home] = value;
                occupied++;
                return 1'b1;
            end
            if (chain_walk(key, hit, tail))
            begin
                vals[hit] = value;
                return 1'b1;
            end
            if (occupied >= SLOTS)
                return 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                pos = (home + i) % SLOTS;
                if (keys[pos] == '0)
                begin
                    keys[pos]     = key;
                    vals[pos]     = value;
                    link[tail]    = pos;
                    link_ok[tail] = 1'b1;
                    occupied++;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void record_request(request_t rq);
            reply_t      rp;
            int unsigned hit;
            int unsigned tail;
            rp = '0;
            case (rq.func)
                FUNC_INSERT: rp.ok = store_pair(rq.key, rq.value);
                FUNC_LOOKUP:
                begin
                    if (rq.key != '0 && chain_walk(rq.key, hit, tail))
                    begin
                        rp.ok          = 1'b1;
                        rp.found_value = vals[hit];
                    end
                end
                FUNC_CLEAR:
                begin
                    wipe();
                    rp.ok = 1'b1;
                end
                default: ;
            endcase
            rp.entry_count = occupied[COUNT_OUT_W-1:0];
            replies_due.push_back(rp);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected result ok=%0d found_value=%h entry_count=%0d",
                         $time, got.ok, got.found_value, got.entry_count);
                error_count++;
                return;
            end
            want = replies_due.pop_front();
            if (got.ok !== want.ok)
            begin
                $display("%0t: ok expected %0d, got %0d", $time, want.ok, got.ok);
                error_count++;
            end
            if (got.found_value !== want.found_value)
            begin
                $display("%0t: found_value expected %h, got %h",
                         $time, want.found_value, got.found_value);
                error_count++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $display("%0t: entry_count expected %0d, got %0d",
                         $time, want.entry_count, got.entry_count);
                error_count++;
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    chtab_in_if  req_if();
    chtab_out_if rsp_if();

    coalesced_hash_table_top #(
        .TABLE_SIZE(SLOTS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_if),
        .out_ch (rsp_if)
    );

    table_shadow      board;
    int               in_idle;
    int               out_idle;
    int               stall_cycles;
    reply_t           seen_reply;
    logic [KEY_W-1:0] key_pool[$];
    logic [7:0]       hot_bytes[4] = '{8'h00, 8'h10, 8'h25, 8'hF7};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: check on each transfer, then pick ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            seen_reply.ok          = rsp_if.ok;
            seen_reply.found_value = rsp_if.found_value;
            seen_reply.entry_count = rsp_if.entry_count;
            board.check_reply(seen_reply);
        end
        rsp_if.ready <= ($urandom_range(99) >= out_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("coalesced_hash_table_top verification failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Called at a rising edge; returns at the edge of the transfer with valid still high.
    task automatic send_request(request_t rq);
        if ($urandom_range(99) < in_idle)
        begin
            req_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_idle);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= rq.func;
        req_if.search_key <= rq.key;
        req_if.new_value  <= rq.value;
        do
            @(posedge clk);
        while (!req_if.ready);
        board.record_request(rq);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    task automatic run_random(int count);
        func_e_t          f;
        logic [KEY_W-1:0] key;
        int unsigned      pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 52)
                f = FUNC_INSERT;
            else if (pick < 94)
                f = FUNC_LOOKUP;
            else if (pick < 97)
                f = FUNC_NOP;
            else
                f = FUNC_CLEAR;
            // mostly keys already seen or sharing a few home slots, to build long chains
            pick = $urandom_range(99);
            if (pick < 45 && key_pool.size() > 0)
                key = key_pool[$urandom_range(key_pool.size() - 1)];
            else if (pick < 80)
                key = {8'($urandom_range(255)), hot_bytes[$urandom_range(3)]};
            else if (pick < 96)
                key = 16'($urandom_range(65535));
            else
                key = '0;
            send_request(request_t'{f, key, 16'($urandom_range(65535))});
            if (f == FUNC_INSERT && key != '0)
            begin
                key_pool.push_back(key);
                if (key_pool.size() > 24)
                    void'(key_pool.pop_front());
            end
            if (f == FUNC_CLEAR)
                key_pool.delete();
            if (n == count / 2 && in_idle != 0)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.func       = FUNC_NOP;
        req_if.search_key = '0;
        req_if.new_value  = '0;
        rsp_if.ready      = 1'b0;
        stall_cycles      = 0;
        in_idle           = 34;
        out_idle          = 77;
        board             = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(request_t'{FUNC_NOP, 16'h0000, 16'hA5A5});
        send_request(request_t'{FUNC_INSERT, 16'h0000, 16'h1111});
        send_request(request_t'{FUNC_LOOKUP, 16'h0000, 16'h0000});
        send_request(request_t'{FUNC_LOOKUP, 16'h1234, 16'h0000});
        send_request(request_t'{FUNC_INSERT, 16'hFFFF, 16'hFFFF});
        send_request(request_t'{FUNC_INSERT, 16'h0100, 16'h0000});
        // same home as 0x0100, then a key whose home was taken by the spill
        send_request(request_t'{FUNC_INSERT, 16'h0200, 16'h2222});
        send_request(request_t'{FUNC_INSERT, 16'h0001, 16'h3333});
        send_request(request_t'{FUNC_INSERT, 16'h0200, 16'h4444});
        send_request(request_t'{FUNC_LOOKUP, 16'h0001, 16'h0000});
        // one long chain from home slot 3 fills the table
        for (int j = 1; j <= 12; j++)
            send_request(request_t'{FUNC_INSERT, {8'(j), 8'h03}, 16'(j * 16'h1111)});
        send_request(request_t'{FUNC_INSERT, 16'h0D03, 16'h5555});
        send_request(request_t'{FUNC_INSERT, 16'h0503, 16'h6666});
        send_request(request_t'{FUNC_LOOKUP, 16'h0C03, 16'h0000});
        send_request(request_t'{FUNC_CLEAR, 16'h0000, 16'h0000});

        run_random(PHASE_ITEMS);
        in_idle  = 77;
        out_idle = 34;
        run_random(PHASE_ITEMS);
        in_idle  = 0;
        out_idle = 0;
        run_random(PHASE_ITEMS);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.error_count == 0 && board.pending() == 0)
            $display("coalesced_hash_table_top verification clean");
        else
            $display("coalesced_hash_table_top verification failed");
        $finish;
    end

endmodule
